### rtl/core/gasp_pkg.sv
package gasp_pkg;

    localparam int PAGE_SIZE = 2048;
    localparam int MAX_PAGES = 8;

    localparam int COORD_W = 12;
    localparam int SUM_W   = COORD_W + 1;
    localparam int POS_W   = 11;
    localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W   = $clog2(MAX_PAGES + 1);

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_MARK  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [2:0] ST_PLACED    = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_DIRTY     = 3'd3;
    localparam logic [2:0] ST_CLEAN     = 3'd4;
    localparam logic [2:0] ST_MARKED    = 3'd5;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] glyph_width;
        logic [COORD_W-1:0] glyph_height;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         page_index;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_right;
        logic [COORD_W-1:0] rect_bottom;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRY_CUR,
        S_TRY_NEW,
        S_PLACE,
        S_FLUSH,
        S_MARK,
        S_WAIT
    } t_state;

endpackage

### rtl/core/glyph_atlas_shelf_packer_core.sv
// Shelf packer for glyph rectangles over up to MAX_PAGES square atlas pages.
// Input channel (i_in_valid / o_in_ready / i_in_item): one request per item:
//   allocate a rectangle, flush dirty rectangles, or mark all pages dirty.
// Output channel (o_out_valid / i_out_ready / o_out_item): results, last
//   set on the final result of a request. Flush gives one result per dirty
//   page (one clean result if none), others one; an unknown request none.
// The block takes one request at a time; o_in_ready is high only when idle.
// Allocate: after acceptance each open page is tried on its current shelf,
//   then on a new shelf, through the shared fit adder/compare unit; a
//   freshly added page needs only the current-shelf try, then a placement
//   step writes the result; an oversized rectangle skips the search.
//   Flush and mark walk the open pages, one page per cycle, a flush pausing on each result.
// Each result is held in an output register until taken; a stalled receiver
//   holds the sequencer, and a flush resumes with the next page once taken.
// Reset (synchronous, active low) leaves one open empty page and no dirty
//   rectangles; no clearing pass follows.
module glyph_atlas_shelf_packer_core
    import gasp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_page_count;
    logic [PAGE_W-1:0]  r_page;
    logic [COORD_W-1:0] r_shelf_x      [MAX_PAGES];
    logic [COORD_W-1:0] r_shelf_y      [MAX_PAGES];
    logic [COORD_W-1:0] r_shelf_bottom [MAX_PAGES];
    logic [MAX_PAGES-1:0] r_dirty_valid;
    logic [COORD_W-1:0] r_dirty_left   [MAX_PAGES];
    logic [COORD_W-1:0] r_dirty_top    [MAX_PAGES];
    logic [COORD_W-1:0] r_dirty_right  [MAX_PAGES];
    logic [COORD_W-1:0] r_dirty_bottom [MAX_PAGES];
    logic [COORD_W-1:0] r_w, r_h;
    t_out_item          r_out;

    logic               in_accept;
    logic               oversize;
    logic [COORD_W-1:0] sx_cur, sy_cur, sb_cur, sb_inc;
    logic               fresh;
    logic [COORD_W-1:0] xe, ye, ny;
    logic [COORD_W-1:0] ux, uy;
    logic [SUM_W-1:0]   sum_x, sum_y;
    logic               fits;
    logic               more_pages;
    logic               can_add;
    logic               later_dirty;
    logic [PAGE_W-1:0]  new_page;
    logic [COORD_W-1:0] pl_l, pl_t, pl_r, pl_b;

    function automatic t_out_item mk_out(
        input logic [2:0]         status,
        input logic [PAGE_W-1:0]  page,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] l,
        input logic [COORD_W-1:0] t,
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] b,
        input logic               last
    );
        t_out_item o;
        o.status      = status;
        o.page_index  = 3'(page);
        o.pos_x       = x[POS_W-1:0];
        o.pos_y       = y[POS_W-1:0];
        o.rect_left   = l;
        o.rect_top    = t;
        o.rect_right  = r;
        o.rect_bottom = b;
        o.last        = last;
        return o;
    endfunction

    assign in_accept = i_in_valid && o_in_ready;
    assign oversize  = (i_in_item.glyph_width > COORD_W'(PAGE_SIZE - 3))
                    || (i_in_item.glyph_height > COORD_W'(PAGE_SIZE - 3));

    always_comb begin
        sx_cur = r_shelf_x[r_page];
        sy_cur = r_shelf_y[r_page];
        sb_cur = r_shelf_bottom[r_page];
        sb_inc = sb_cur + COORD_W'(1);
        fresh  = (sx_cur == '0) || (sy_cur == '0);
        xe     = fresh ? COORD_W'(1) : sx_cur;
        ye     = fresh ? COORD_W'(1) : sy_cur;
        ny     = (sy_cur > sb_inc) ? sy_cur : sb_inc;
        case (r_state)
            S_TRY_CUR: begin
                ux = xe;
                uy = ye;
            end
            S_TRY_NEW: begin
                ux = COORD_W'(1);
                uy = ny;
            end
            default: begin
                ux = sx_cur;
                uy = sy_cur;
            end
        endcase
        sum_x = {1'b0, ux} + {1'b0, r_w};
        sum_y = {1'b0, uy} + {1'b0, r_h};
        fits  = (sum_x < SUM_W'(PAGE_SIZE - 1)) && (sum_y < SUM_W'(PAGE_SIZE - 1));
        more_pages = (CNT_W'(r_page) + CNT_W'(1)) < r_page_count;
        can_add    = r_page_count < CNT_W'(MAX_PAGES);
        new_page   = r_page_count[PAGE_W-1:0];
        later_dirty = 1'b0;
        for (int i = 0; i < MAX_PAGES; i++) begin
            if (i > int'(r_page) && r_dirty_valid[i]) begin
                later_dirty = 1'b1;
            end
        end
        pl_l = sx_cur - COORD_W'(1);
        pl_t = sy_cur - COORD_W'(1);
        pl_r = sum_x[COORD_W-1:0] + COORD_W'(1);
        pl_b = sum_y[COORD_W-1:0] + COORD_W'(1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_item.req_type)
                        REQ_ALLOC: n_state = oversize ? S_WAIT : S_TRY_CUR;
                        REQ_FLUSH: n_state = S_FLUSH;
                        REQ_MARK:  n_state = S_MARK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TRY_CUR: n_state = fits ? S_PLACE : S_TRY_NEW;
            S_TRY_NEW: begin
                if (fits) begin
                    n_state = S_PLACE;
                end else if (more_pages || can_add) begin
                    n_state = S_TRY_CUR;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_PLACE: n_state = S_WAIT;
            S_FLUSH: begin
                if (r_dirty_valid[r_page] || !more_pages) begin
                    n_state = S_WAIT;
                end
            end
            S_MARK: begin
                if (!more_pages) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_state = r_out.last ? S_IDLE : S_FLUSH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_WAIT);
        o_out_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_page_count  <= CNT_W'(1);
            r_page        <= '0;
            r_dirty_valid <= '0;
            for (int i = 0; i < MAX_PAGES; i++) begin
                r_shelf_x[i]      <= '0;
                r_shelf_y[i]      <= '0;
                r_shelf_bottom[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_page <= '0;
                    end
                end
                S_TRY_CUR: begin
                    if (fresh) begin
                        r_shelf_x[r_page] <= COORD_W'(1);
                        r_shelf_y[r_page] <= COORD_W'(1);
                    end
                end
                S_TRY_NEW: begin
                    if (fits) begin
                        r_shelf_x[r_page] <= COORD_W'(1);
                        r_shelf_y[r_page] <= ny;
                    end else if (more_pages) begin
                        r_page <= r_page + PAGE_W'(1);
                    end else if (can_add) begin
                        r_shelf_x[new_page]      <= '0;
                        r_shelf_y[new_page]      <= '0;
                        r_shelf_bottom[new_page] <= '0;
                        r_dirty_valid[new_page]  <= 1'b0;
                        r_page_count             <= r_page_count + CNT_W'(1);
                        r_page                   <= new_page;
                    end
                end
                S_PLACE: begin
                    r_shelf_x[r_page]     <= pl_r;
                    r_dirty_valid[r_page] <= 1'b1;
                    if (sum_y[COORD_W-1:0] > sb_cur) begin
                        r_shelf_bottom[r_page] <= sum_y[COORD_W-1:0];
                    end
                end
                S_FLUSH: begin
                    r_dirty_valid[r_page] <= 1'b0;
                    r_page                <= r_page + PAGE_W'(1);
                end
                S_MARK: begin
                    r_dirty_valid[r_page] <= 1'b1;
                    r_page                <= r_page + PAGE_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_w   <= i_in_item.glyph_width;
                    r_h   <= i_in_item.glyph_height;
                    r_out <= mk_out(ST_TOO_LARGE, '0, '0, '0, '0, '0, '0, '0, 1'b1);
                end
            end
            S_TRY_NEW: begin
                r_out <= mk_out(ST_EXHAUSTED, '0, '0, '0, '0, '0, '0, '0, 1'b1);
            end
            S_PLACE: begin
                if (!r_dirty_valid[r_page]) begin
                    r_dirty_left[r_page]   <= pl_l;
                    r_dirty_top[r_page]    <= pl_t;
                    r_dirty_right[r_page]  <= pl_r;
                    r_dirty_bottom[r_page] <= pl_b;
                end else begin
                    if (pl_l < r_dirty_left[r_page]) begin
                        r_dirty_left[r_page] <= pl_l;
                    end
                    if (pl_t < r_dirty_top[r_page]) begin
                        r_dirty_top[r_page] <= pl_t;
                    end
                    if (pl_r > r_dirty_right[r_page]) begin
                        r_dirty_right[r_page] <= pl_r;
                    end
                    if (pl_b > r_dirty_bottom[r_page]) begin
                        r_dirty_bottom[r_page] <= pl_b;
                    end
                end
                r_out <= mk_out(ST_PLACED, r_page, sx_cur, sy_cur,
                                '0, '0, '0, '0, 1'b1);
            end
            S_FLUSH: begin
                if (r_dirty_valid[r_page]) begin
                    r_out <= mk_out(ST_DIRTY, r_page, '0, '0,
                                    r_dirty_left[r_page], r_dirty_top[r_page],
                                    r_dirty_right[r_page], r_dirty_bottom[r_page],
                                    !later_dirty);
                end else begin
                    r_out <= mk_out(ST_CLEAN, '0, '0, '0, '0, '0, '0, '0, 1'b1);
                end
            end
            S_MARK: begin
                r_dirty_left[r_page]   <= '0;
                r_dirty_top[r_page]    <= '0;
                r_dirty_right[r_page]  <= COORD_W'(PAGE_SIZE);
                r_dirty_bottom[r_page] <= sb_inc;
                r_out <= mk_out(ST_MARKED, '0, '0, '0, '0, '0, '0, '0, 1'b1);
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_page_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_page_count != '0) && (r_page_count <= CNT_W'(MAX_PAGES)))
        else $error("page count out of range");

    a_ready_excl_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_placed_page_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_PLACED))
        |-> (CNT_W'(o_out_item.page_index) < r_page_count))
        else $error("placement on a page that is not open");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_item.req_type != REQ_NONE)) |=> !o_in_ready)
        else $error("ready right after taking a request");
`endif

endmodule
